// File: rtl/mzc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mzc_pkg;

  localparam int unsigned COORD_W = 32;
  localparam int unsigned COMP_W  = 31;
  localparam int unsigned Z_W     = 62;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // quotient bits resolved per divider stage
  localparam int unsigned DIV_BITS_PER_STAGE = 3;

  typedef enum logic [1:0] {
    OP_INTERLEAVE = 2'd0,
    OP_QUANTIZE   = 2'd1,
    OP_SPLIT      = 2'd2,
    OP_NONE       = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SPAN  = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIMS  = 3'd0,
    CFG_DEPTH = 3'd1,
    CFG_MIN0  = 3'd2,
    CFG_MAX0  = 3'd3,
    CFG_MIN1  = 3'd4,
    CFG_MAX1  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    op_e                       operation;
    logic signed [COORD_W-1:0] coord0;
    logic signed [COORD_W-1:0] coord1;
    logic [Z_W-1:0]            zvalue_in;
  } in_item_t;

  typedef struct packed {
    logic [Z_W-1:0]    zvalue_out;
    logic [COMP_W-1:0] component0;
    logic [COMP_W-1:0] component1;
    status_e           status;
  } out_item_t;

  // per-lane quantizer result
  typedef struct packed {
    logic [COMP_W-1:0] comp;
    logic              range_err;
    logic              zero_span;
  } quant_res_t;

  // registers from quantizer input to its registered result
  function automatic int unsigned quant_lat(input int unsigned max_depth);
    return (COORD_W + max_depth + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE + 3;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mzc_quant.sv
`timescale 1ns / 1ps
`default_nettype none

module mzc_quant #(
  parameter int unsigned MAX_DEPTH = 31
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 valid_i,
  input  wire logic signed [mzc_pkg::COORD_W-1:0]   coord_i,
  input  wire logic signed [mzc_pkg::COORD_W-1:0]   min_i,
  input  wire logic signed [mzc_pkg::COORD_W-1:0]   max_i,
  input  wire logic [4:0]                           depth_i,
  input  wire logic [mzc_pkg::COMP_W-1:0]           range_i,
  output mzc_pkg::quant_res_t                       res_o
);
  import mzc_pkg::*;

  localparam int unsigned DVD_W = COORD_W + MAX_DEPTH;
  localparam int unsigned NSTG  = (DVD_W + DIV_BITS_PER_STAGE - 1) / DIV_BITS_PER_STAGE;
  localparam int unsigned PAD_W = NSTG * DIV_BITS_PER_STAGE;

  typedef struct packed {
    logic [COORD_W-1:0] rem;
    logic [PAD_W-1:0]   dvd;
    logic [COORD_W-1:0] quo;
    logic               ovf;
    logic [COORD_W-1:0] dsr;
    logic               neg;
    logic               zs;
  } div_t;

  // difference stage
  logic               dv_q;
  logic [COORD_W-1:0] an_q, an_d;
  logic [COORD_W-1:0] as_q, as_d;
  logic               neg_q, neg_d;
  logic               zs_q, zs_d;

  always_comb begin
    logic [COORD_W:0] num;
    logic [COORD_W:0] span;
    logic [COORD_W:0] anum;
    logic [COORD_W:0] aspan;
    num   = {coord_i[COORD_W-1], coord_i} - {min_i[COORD_W-1], min_i};
    span  = {max_i[COORD_W-1], max_i} - {min_i[COORD_W-1], min_i};
    anum  = num[COORD_W] ? (-num) : num;
    aspan = span[COORD_W] ? (-span) : span;
    an_d  = anum[COORD_W-1:0];
    as_d  = aspan[COORD_W-1:0];
    neg_d = num[COORD_W] ^ span[COORD_W];
    zs_d  = (span == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_q <= 1'b0;
    end else begin
      dv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i) begin
      an_q  <= an_d;
      as_q  <= as_d;
      neg_q <= neg_d;
      zs_q  <= zs_d;
    end
  end

  // scale stage: an * (2^depth - 1) as a shift and subtract; stage 0 of the chain
  logic vq [NSTG+1];
  div_t dq_q [NSTG+1];
  div_t sc_d;

  always_comb begin
    logic [PAD_W-1:0] an_ext;
    an_ext   = PAD_W'(an_q);
    sc_d     = '0;
    sc_d.dvd = (an_ext << depth_i) - an_ext;
    sc_d.dsr = as_q;
    sc_d.neg = neg_q;
    sc_d.zs  = zs_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vq[0] <= 1'b0;
    end else begin
      vq[0] <= dv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_q) begin
      dq_q[0] <= sc_d;
    end
  end

  // restoring divider, three quotient bits per stage
  for (genvar k = 0; k < NSTG; k++) begin : g_div
    div_t stg_d;

    always_comb begin
      logic [COORD_W:0] t;
      stg_d = dq_q[k];
      for (int j = 0; j < DIV_BITS_PER_STAGE; j++) begin
        t         = {stg_d.rem, stg_d.dvd[PAD_W-1]};
        stg_d.dvd = stg_d.dvd << 1;
        stg_d.ovf = stg_d.ovf | stg_d.quo[COORD_W-1];
        if (t >= {1'b0, stg_d.dsr}) begin
          t         = t - {1'b0, stg_d.dsr};
          stg_d.quo = {stg_d.quo[COORD_W-2:0], 1'b1};
        end else begin
          stg_d.quo = {stg_d.quo[COORD_W-2:0], 1'b0};
        end
        stg_d.rem = t[COORD_W-1:0];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vq[k+1] <= 1'b0;
      end else begin
        vq[k+1] <= vq[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (vq[k]) begin
        dq_q[k+1] <= stg_d;
      end
    end
  end

  // rounding, sign and range check
  quant_res_t res_q, res_d;

  always_comb begin
    div_t               f;
    logic               rnd;
    logic [COORD_W:0]   q1;
    logic               hi;
    logic               nz;
    logic               gt;
    logic [COMP_W-1:0]  mag;
    logic [COMP_W-1:0]  sv;
    f   = dq_q[NSTG];
    rnd = ({f.rem, 1'b0} >= {1'b0, f.dsr});
    q1  = {1'b0, f.quo} + (COORD_W+1)'(rnd);
    hi  = f.ovf | q1[COORD_W];
    nz  = hi | (q1[COORD_W-1:0] != '0);
    gt  = hi | (q1[COORD_W-1:0] > {1'b0, range_i});
    mag = q1[COMP_W-1:0];
    sv  = f.neg ? (-mag) : mag;
    res_d.range_err = f.neg ? nz : gt;
    res_d.zero_span = f.zs;
    res_d.comp      = f.zs ? '0 : (sv & range_i);
  end

  always_ff @(posedge clk_i) begin
    if (vq[NSTG]) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

// File: rtl/morton_zorder_codec.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake                         | payload
// ----------+-----------------------------------+---------------------------
// item in   | start, busy (taken: start & !busy)| item_i   (in_item_t)
// result    | res_valid_o (one-cycle strobe)    | result_o (out_item_t)
// config    | cfg_valid_i, cfg_ready_o          | cfg_index_i, cfg_data_i
//
// one item per clock while busy is low; each result passes the input register,
// the item side chain, as long as the quantizer lanes, and the result register;
// lane length is set by the restoring divider, three quotient bits per stage
// busy is high only in the first cycle after reset; no clearing pass
// the result side cannot stall, so the pipeline never holds; every beat moves on
// all operations take the same path length, so results leave in item order

module morton_zorder_codec #(
  parameter int unsigned MAX_DIMS  = 2,
  parameter int unsigned MAX_DEPTH = 31
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               start,
  output logic                                    busy,
  input  wire mzc_pkg::in_item_t                  item_i,
  output logic                                    res_valid_o,
  output mzc_pkg::out_item_t                      result_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [mzc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [mzc_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import mzc_pkg::*;

  localparam int unsigned LAT = quant_lat(MAX_DEPTH);

  // ready after reset
  logic rdy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rdy_q <= 1'b0;
    end else begin
      rdy_q <= 1'b1;
    end
  end

  assign busy        = ~rdy_q;
  assign cfg_ready_o = rdy_q;

  // configuration registers
  logic [1:0]                dims_q;
  logic [4:0]                depth_q;
  logic signed [COORD_W-1:0] min0_q, max0_q, min1_q, max1_q;
  logic                      cfg_we;

  assign cfg_we = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dims_q  <= 2'd2;
      depth_q <= 5'd16;
      min0_q  <= '0;
      max0_q  <= COORD_W'(1);
      min1_q  <= '0;
      max1_q  <= COORD_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_DIMS:  dims_q  <= cfg_data_i[1:0];
        CFG_DEPTH: depth_q <= cfg_data_i[4:0];
        CFG_MIN0:  min0_q  <= cfg_data_i;
        CFG_MAX0:  max0_q  <= cfg_data_i;
        CFG_MIN1:  min1_q  <= cfg_data_i;
        CFG_MAX1:  max1_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // clamped dims/depth and the component mask, registered from the config registers
  logic              two_d_q, two_d_d;
  logic [4:0]        dep_q, dep_d;
  logic [COMP_W-1:0] range_q, range_d;

  always_comb begin
    two_d_d = (dims_q >= 2'd2) && (MAX_DIMS >= 2);
    if (depth_q == '0) begin
      dep_d = 5'd1;
    end else if (depth_q > 5'(MAX_DEPTH)) begin
      dep_d = 5'(MAX_DEPTH);
    end else begin
      dep_d = depth_q;
    end
    for (int k = 0; k < COMP_W; k++) begin
      range_d[k] = (k < int'(dep_d));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      two_d_q <= 1'b1;
      dep_q   <= 5'd16;
      range_q <= COMP_W'(16'hFFFF);
    end else begin
      two_d_q <= two_d_d;
      dep_q   <= dep_d;
      range_q <= range_d;
    end
  end

  // input register
  logic     v0_q;
  in_item_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start & ~busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start & ~busy) begin
      in_q <= item_i;
    end
  end

  // quantizer lanes
  quant_res_t q0, q1;

  mzc_quant #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_lane0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .coord_i (in_q.coord0),
    .min_i   (min0_q),
    .max_i   (max0_q),
    .depth_i (dep_q),
    .range_i (range_q),
    .res_o   (q0)
  );

  if (MAX_DIMS > 1) begin : g_lane1
    mzc_quant #(
      .MAX_DEPTH (MAX_DEPTH)
    ) u_lane1 (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (v0_q),
      .coord_i (in_q.coord1),
      .min_i   (min1_q),
      .max_i   (max1_q),
      .depth_i (dep_q),
      .range_i (range_q),
      .res_o   (q1)
    );
  end else begin : g_no_lane1
    assign q1 = '0;
  end

  // item fields ride alongside the quantizer lanes
  logic     sv_q [LAT];
  in_item_t side_q [LAT];

  for (genvar s = 0; s < LAT; s++) begin : g_side
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          sv_q[s] <= 1'b0;
        end else begin
          sv_q[s] <= v0_q;
        end
      end
      always_ff @(posedge clk_i) begin
        if (v0_q) begin
          side_q[s] <= in_q;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          sv_q[s] <= 1'b0;
        end else begin
          sv_q[s] <= sv_q[s-1];
        end
      end
      always_ff @(posedge clk_i) begin
        if (sv_q[s-1]) begin
          side_q[s] <= side_q[s-1];
        end
      end
    end
  end

  // result assembly: pick components, interleave or split, set status
  logic      res_v_q;
  out_item_t res_q, res_d;

  always_comb begin
    in_item_t          it;
    logic [COMP_W-1:0] c0;
    logic [COMP_W-1:0] c1;
    logic              err;
    logic              zsp;
    logic [Z_W-1:0]    z;
    it  = side_q[LAT-1];
    c0  = '0;
    c1  = '0;
    err = 1'b0;
    zsp = 1'b0;
    z   = '0;
    res_d = '0;
    case (it.operation)
      OP_INTERLEAVE: begin
        c0  = it.coord0[COMP_W-1:0] & range_q;
        err = it.coord0[COORD_W-1] | (it.coord0[COMP_W-1:0] > range_q);
        if (two_d_q) begin
          c1  = it.coord1[COMP_W-1:0] & range_q;
          err = err | it.coord1[COORD_W-1] | (it.coord1[COMP_W-1:0] > range_q);
        end
      end
      OP_QUANTIZE: begin
        c0  = q0.comp;
        err = q0.range_err;
        zsp = q0.zero_span;
        if (two_d_q) begin
          c1  = q1.comp;
          err = err | q1.range_err;
          zsp = zsp | q1.zero_span;
        end
      end
      OP_SPLIT: begin
        for (int k = 0; k < COMP_W; k++) begin
          if (two_d_q) begin
            c0[k] = it.zvalue_in[2*k];
            c1[k] = it.zvalue_in[2*k+1];
          end else begin
            c0[k] = it.zvalue_in[k];
          end
        end
        c0 = c0 & range_q;
        c1 = c1 & range_q;
      end
      default: begin
      end
    endcase

    // highest dimension sits in the upper bit of each level
    if (it.operation == OP_INTERLEAVE || it.operation == OP_QUANTIZE) begin
      for (int k = 0; k < COMP_W; k++) begin
        if (two_d_q) begin
          z[2*k]   = c0[k];
          z[2*k+1] = c1[k];
        end else begin
          z[k] = c0[k];
        end
      end
      res_d.status = zsp ? ST_SPAN : (err ? ST_RANGE : ST_OK);
    end else begin
      res_d.status = ST_OK;
    end
    res_d.zvalue_out = z;
    res_d.component0 = c0;
    res_d.component1 = c1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= sv_q[LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q[LAT-1]) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_v_q;
  assign result_o    = res_q;

endmodule

`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mzc_pkg::*;

  localparam int unsigned CLK_PERIOD     = 4;
  localparam int unsigned RESET_CYCLES   = 12;
  // settle time at the end, after the last result is back
  localparam int unsigned SETTLE_CYCLES  = 40;
  // longest legal quiet spell is the longest sender gap or one pipeline flush
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS    = 125;
  localparam int unsigned MAX_PRINTED    = 40;

  // one full register setting of the codec
  typedef struct packed {
    logic [1:0]         dims;
    logic [4:0]         depth;
    logic signed [31:0] min0;
    logic signed [31:0] max0;
    logic signed [31:0] min1;
    logic signed [31:0] max1;
  } cfg_t;

  // expected z values and components, predicted beat by beat
  class zorder_scoreboard;
    logic [1:0]         dims_reg;
    logic [4:0]         depth_reg;
    logic signed [31:0] min_b [2];
    logic signed [31:0] max_b [2];
    out_item_t          expected_q [$];
    int unsigned        mismatches;

    function new();
      dims_reg   = 2'd2;
      depth_reg  = 5'd16;
      min_b      = '{32'sd0, 32'sd0};
      max_b      = '{32'sd1, 32'sd1};
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] data);
      case (idx)
        CFG_DIMS:  dims_reg  = data[1:0];
        CFG_DEPTH: depth_reg = data[4:0];
        CFG_MIN0:  min_b[0]  = data;
        CFG_MAX0:  max_b[0]  = data;
        CFG_MIN1:  min_b[1]  = data;
        CFG_MAX1:  max_b[1]  = data;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // round((v - lo) / (hi - lo) * full_scale), ties away from zero, exact
    function longint quantize(longint v, longint lo, longint hi,
                              longint unsigned full_scale, output bit zero_span);
      longint          num;
      longint          span;
      longint unsigned mag_num;
      longint unsigned mag_span;
      longint unsigned prod;
      longint unsigned quo;
      longint unsigned rem;
      bit              neg;
      num       = v - lo;
      span      = hi - lo;
      zero_span = (span == 0);
      if (span == 0) return 0;
      mag_num  = (num < 0) ? -num : num;
      mag_span = (span < 0) ? -span : span;
      neg      = (num < 0) != (span < 0);
      prod     = mag_num * full_scale;
      quo      = prod / mag_span;
      rem      = prod % mag_span;
      if (rem >= mag_span - rem) quo++;
      return neg ? -longint'(quo) : longint'(quo);
    endfunction

    function out_item_t predict(in_item_t it);
      int unsigned     n_dims;
      int unsigned     n_depth;
      int unsigned     pos;
      int              lvl;
      int              d;
      logic [63:0]     full_scale;
      logic [63:0]     z;
      logic [63:0]     comp [2];
      longint          coord [2];
      longint          val;
      bit              span_err;
      bit              range_err;
      bit              zs;
      out_item_t       res;
      // out-of-range settings clamp to the nearest legal value
      n_dims     = (dims_reg == 0) ? 1 : ((dims_reg > 2) ? 2 : dims_reg);
      n_depth    = (depth_reg == 0) ? 1 : depth_reg;
      full_scale = (64'd1 << n_depth) - 64'd1;
      coord[0]   = it.coord0;
      coord[1]   = it.coord1;
      comp       = '{64'd0, 64'd0};
      z          = '0;
      span_err   = 1'b0;
      range_err  = 1'b0;
      res        = '0;
      case (it.operation)
        OP_INTERLEAVE, OP_QUANTIZE: begin
          for (int i = 0; i < n_dims; i++) begin
            val = coord[i];
            if (it.operation == OP_QUANTIZE) begin
              val = quantize(coord[i], min_b[i], max_b[i], full_scale, zs);
              if (zs) span_err = 1'b1;
            end
            if (val < 0 || val > longint'(full_scale)) range_err = 1'b1;
            // negative components still go in as their low two's complement bits
            comp[i] = val & full_scale;
          end
          // msb level first, highest dimension first within a level
          for (lvl = n_depth; lvl > 0; lvl--) begin
            for (d = n_dims - 1; d >= 0; d--) begin
              z = (z << 1) | ((comp[d] >> (lvl - 1)) & 64'd1);
            end
          end
          res.zvalue_out = z[Z_W-1:0];
          res.status     = span_err ? ST_SPAN : (range_err ? ST_RANGE : ST_OK);
        end
        OP_SPLIT: begin
          // bits above depth * dims are ignored
          pos = n_depth * n_dims;
          for (lvl = 0; lvl < n_depth; lvl++) begin
            for (d = n_dims - 1; d >= 0; d--) begin
              pos--;
              comp[d] = (comp[d] << 1) | ((it.zvalue_in >> pos) & 64'd1);
            end
          end
        end
        default: ;
      endcase
      if (it.operation != OP_NONE) begin
        res.component0 = comp[0][COMP_W-1:0];
        res.component1 = comp[1][COMP_W-1:0];
      end
      return res;
    endfunction

    function void note_item(in_item_t it);
      expected_q.insert(expected_q.size(), predict(it));
    endfunction

    // every mismatch is counted, only the first few are printed
    task report(string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTED) $display("%0t ns: %s", $realtime, msg);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing pending, z=%h", got.zvalue_out));
        return;
      end
      want = expected_q.pop_front();
      if (got.zvalue_out !== want.zvalue_out)
        report($sformatf("zvalue_out %h, want %h", got.zvalue_out, want.zvalue_out));
      if (got.component0 !== want.component0)
        report($sformatf("component0 %h, want %h", got.component0, want.component0));
      if (got.component1 !== want.component1)
        report($sformatf("component1 %h, want %h", got.component1, want.component1));
      if (got.status !== want.status)
        report($sformatf("status %0d, want %0d", got.status, want.status));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  in_item_t              item_i;
  logic                  res_valid_o;
  out_item_t             result_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  zorder_scoreboard sb;
  int unsigned      idle_cycles;

  morton_zorder_codec #(
    .MAX_DIMS  (2),
    .MAX_DEPTH (31)
  ) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(CLK_PERIOD / 2.0) clk_i = ~clk_i;

  // result beats are sampled at the edge that ends their strobe cycle;
  // the watchdog restarts on any beat on any of the three channels
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_valid_o === 1'b1) sb.check_result(result_o);
    if ((start && busy === 1'b0) || res_valid_o === 1'b1 ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: %0d cycles with no beat", idle_cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // sender gap: mostly none, some short, a few long
  function automatic int unsigned pick_gap(bit quiet);
    int unsigned sel;
    if (quiet) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 0;
    if (sel < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // start stays high back to back; it only drops when a gap follows or the sender waits for idle
  task automatic send_item(in_item_t it, bit quiet);
    int unsigned gap;
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    sb.note_item(it);
    gap = pick_gap(quiet);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_fields(op_e op, logic [31:0] c0, logic [31:0] c1,
                             logic [Z_W-1:0] zin);
    in_item_t it;
    it.operation = op;
    it.coord0    = c0;
    it.coord1    = c1;
    it.zvalue_in = zin;
    send_item(it, 1'b0);
  endtask

  // hold off the sender until every pending result is back
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // all six registers in one burst, valid held high across beats
  task automatic apply_config(cfg_t c);
    logic [31:0] vals [6];
    logic [31:0] junk;
    cfg_idx_e    idx;
    junk            = $urandom;
    // upper bits of the narrow registers are don't-care, so fill them
    vals[CFG_DIMS]  = {junk[31:2], c.dims};
    vals[CFG_DEPTH] = {junk[31:5], c.depth};
    vals[CFG_MIN0]  = c.min0;
    vals[CFG_MAX0]  = c.max0;
    vals[CFG_MIN1]  = c.min1;
    vals[CFG_MAX1]  = c.max1;
    idx             = CFG_DIMS;
    cfg_valid_i    <= 1'b1;
    do begin
      cfg_index_i <= idx;
      cfg_data_i  <= vals[idx];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      sb.set_reg(idx, vals[idx]);
      idx = idx.next();
    end while (idx != CFG_DIMS);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic void random_bounds(output logic signed [31:0] lo,
                                        output logic signed [31:0] hi);
    logic signed [31:0] a;
    logic signed [31:0] b;
    int unsigned        sel;
    sel = $urandom_range(0, 9);
    a   = $signed($urandom) >>> $urandom_range(0, 31);
    b   = $signed($urandom) >>> $urandom_range(0, 31);
    case (sel)
      0: begin
        lo = a;
        hi = a;
      end
      1: begin
        lo = 32'h8000_0000;
        hi = 32'h7fff_ffff;
      end
      2: begin
        // reversed bounds, negative span
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end
      default: begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
    endcase
  endfunction

  function automatic cfg_t random_config();
    cfg_t        c;
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) c.dims = 2'd0;
    else if (sel == 1) c.dims = 2'd3;
    else c.dims = 2'($urandom_range(1, 2));
    sel = $urandom_range(0, 9);
    if (sel < 2) c.depth = 5'd0;
    else if (sel < 4) c.depth = 5'd31;
    else if (sel < 5) c.depth = 5'd1;
    else c.depth = 5'($urandom_range(1, 31));
    random_bounds(c.min0, c.max0);
    random_bounds(c.min1, c.max1);
    return c;
  endfunction

  // a coordinate inside [a, b] in either order, endpoints favored
  function automatic logic [31:0] point_in(logic signed [31:0] a,
                                           logic signed [31:0] b);
    longint      lo_b;
    longint      hi_b;
    longint      width;
    longint      pick;
    logic [63:0] r64;
    int unsigned sel;
    lo_b  = (a < b) ? a : b;
    hi_b  = (a < b) ? b : a;
    width = hi_b - lo_b + 1;
    r64   = {$urandom, $urandom};
    sel   = $urandom_range(0, 9);
    if (sel == 0) pick = lo_b;
    else if (sel == 1) pick = hi_b;
    else pick = lo_b + longint'(r64 % width);
    return pick[31:0];
  endfunction

  function automatic in_item_t random_item(cfg_t c);
    in_item_t    it;
    logic [63:0] r64;
    int unsigned n_depth;
    int unsigned full_scale;
    int unsigned sel;
    r64          = {$urandom, $urandom};
    it.zvalue_in = r64[Z_W-1:0];
    it.coord0    = $urandom;
    it.coord1    = $urandom;
    n_depth      = (c.depth == 0) ? 1 : c.depth;
    full_scale   = (32'd1 << n_depth) - 1;
    sel          = $urandom_range(0, 99);
    if (sel < 30) it.operation = OP_INTERLEAVE;
    else if (sel < 70) it.operation = OP_QUANTIZE;
    else if (sel < 95) it.operation = OP_SPLIT;
    else it.operation = OP_NONE;
    // mostly in-range operands, the rest left as raw 32 bit noise
    if (it.operation == OP_INTERLEAVE) begin
      if ($urandom_range(0, 3) != 0) it.coord0 = $urandom_range(0, full_scale);
      if ($urandom_range(0, 3) != 0) it.coord1 = $urandom_range(0, full_scale);
    end else if (it.operation == OP_QUANTIZE) begin
      if ($urandom_range(0, 4) != 0) it.coord0 = point_in(c.min0, c.max0);
      if ($urandom_range(0, 4) != 0) it.coord1 = point_in(c.min1, c.max1);
    end
    return it;
  endfunction

  initial begin
    cfg_t c;
    bit   quiet;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_DIMS;
    cfg_data_i  = '0;
    idle_cycles = 0;
    sb          = new();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset setting: two dims, depth 16, unit spans
    send_fields(OP_INTERLEAVE, 32'd0, 32'd0, '0);
    send_fields(OP_INTERLEAVE, 32'h0000_ffff, 32'h0000_ffff, '0);
    send_fields(OP_INTERLEAVE, 32'h0001_0000, 32'd0, '0);         // one past full scale
    send_fields(OP_INTERLEAVE, 32'hffff_ffff, 32'd5, '0);         // negative component
    send_fields(OP_INTERLEAVE, 32'h7fff_ffff, 32'h8000_0000, '0);
    send_fields(OP_QUANTIZE, 32'd0, 32'd1, '0);                   // at min and max
    send_fields(OP_QUANTIZE, 32'd2, 32'hffff_ffff, '0);           // outside the bounds
    send_fields(OP_QUANTIZE, 32'h7fff_ffff, 32'h8000_0000, '0);
    send_fields(OP_SPLIT, 32'd0, 32'd0, '1);
    send_fields(OP_SPLIT, 32'hffff_ffff, 32'hffff_ffff, '0);
    send_fields(OP_SPLIT, 32'd0, 32'd0, 62'h2aaa_aaaa_aaaa_aaaa);
    send_fields(OP_NONE, 32'hffff_ffff, 32'hffff_ffff, '1);

    // one dim at depth 1, span 2: halfway points round away from zero;
    // dim 1 has zero span but is not in use
    wait_idle();
    apply_config('{dims: 2'd1, depth: 5'd1, min0: 32'sd0, max0: 32'sd2,
                   min1: 32'sd5, max1: 32'sd5});
    send_fields(OP_QUANTIZE, 32'd1, 32'd0, '0);
    send_fields(OP_QUANTIZE, 32'hffff_ffff, 32'd0, '0);
    send_fields(OP_QUANTIZE, 32'd3, 32'd0, '0);
    send_fields(OP_INTERLEAVE, 32'd1, 32'd123, '0);
    send_fields(OP_SPLIT, 32'd0, 32'd0, '1);

    // dims 0 and depth 0 clamp to 1; zero span wins over out of range
    wait_idle();
    apply_config('{dims: 2'd0, depth: 5'd0, min0: 32'sd7, max0: 32'sd7,
                   min1: 32'sd0, max1: -32'sd1});
    send_fields(OP_QUANTIZE, 32'd7, 32'd0, '0);
    send_fields(OP_QUANTIZE, -32'sd100, 32'd0, '0);
    send_fields(OP_INTERLEAVE, 32'd2, 32'd0, '0);

    // dims 3 clamps to 2; depth 31 with full-width spans, one reversed
    wait_idle();
    apply_config('{dims: 2'd3, depth: 5'd31, min0: 32'h8000_0000, max0: 32'h7fff_ffff,
                   min1: 32'h7fff_ffff, max1: 32'h8000_0000});
    send_fields(OP_QUANTIZE, 32'h8000_0000, 32'h8000_0000, '0);
    send_fields(OP_QUANTIZE, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    send_fields(OP_QUANTIZE, 32'd0, 32'd0, '0);
    send_fields(OP_INTERLEAVE, 32'h7fff_ffff, 32'h7fff_ffff, '0);
    send_fields(OP_SPLIT, 32'd0, 32'd0, '1);

    // random phases, each under its own setting; two run back to back
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      c = random_config();
      if (p == 0) begin
        c.dims  = 2'd2;
        c.depth = 5'd31;
      end else if (p == 1) begin
        c.dims  = 2'd1;
        c.depth = 5'd1;
      end
      apply_config(c);
      quiet = (p == 3 || p == 7);
      for (int n = 0; n < PHASE_ITEMS; n++) send_item(random_item(c), quiet);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
